>>> rtl/core/mrop_pkg.sv
package mrop_pkg;

   localparam int MAX_RECTS  = 64;
   localparam int COORD_BITS = 16;
   localparam int FIELD_W    = 16;
   localparam int COUNT_W    = 7;
   localparam int STATUS_W   = 2;

   localparam int ADDR_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int CNT_W  = $clog2(MAX_RECTS + 1);
   localparam int CAND_W = $clog2(2 * MAX_RECTS);

   localparam int REQ_DATA_W  = 4 * FIELD_W;
   localparam int RSP_USED_W  = 2 * FIELD_W + COUNT_W + STATUS_W;
   localparam int RSP_DATA_W  = ((RSP_USED_W + 7) / 8) * 8;

   localparam int ERR_OVERFLOW_BIT  = 0;
   localparam int ERR_MALFORMED_BIT = 1;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHKN,
      S_LDX,
      S_CHKB,
      S_COUNT,
      S_UPDATE,
      S_NEXTB,
      S_NEXTA,
      S_DONE
   } step_type;

   typedef enum logic [3:0] {
      OP_ACCEPT,
      OP_NONE,
      OP_LOAD_X,
      OP_LOAD_Y,
      OP_COUNT,
      OP_UPDATE,
      OP_STEP_B,
      OP_STEP_A,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      ADDR_A,
      ADDR_B,
      ADDR_C0,
      ADDR_CNEXT,
      ADDR_BNEXT,
      ADDR_ANEXT
   } addr_sel_type;

   typedef enum logic [2:0] {
      C_ALWAYS,
      C_START,
      C_EMPTY,
      C_COVER,
      C_C_LAST,
      C_B_LAST,
      C_A_LAST,
      C_OUT_FREE
   } cond_type;

   typedef struct packed {
      op_type       op;
      addr_sel_type addr_sel;
      cond_type     cond;
      step_type     jump;
      step_type     next;
   } uword_type;

   typedef struct packed {
      op_type       op;
      addr_sel_type addr_sel;
   } ctrl_type;

   typedef struct packed {
      logic start;
      logic empty;
      logic covered;
      logic c_last;
      logic b_last;
      logic a_last;
      logic out_free;
   } flags_type;

   // Control store: the jump target is taken when the condition holds,
   // otherwise the sequencer moves to the next field.
   function automatic uword_type ucode_rom(step_type step);
      uword_type word;
      unique case (step)
         S_IDLE:   word = '{OP_ACCEPT, ADDR_A,     C_START,    S_CHKN,   S_IDLE};
         S_CHKN:   word = '{OP_NONE,   ADDR_A,     C_EMPTY,    S_DONE,   S_LDX};
         S_LDX:    word = '{OP_LOAD_X, ADDR_B,     C_ALWAYS,   S_CHKB,   S_CHKB};
         S_CHKB:   word = '{OP_LOAD_Y, ADDR_C0,    C_COVER,    S_COUNT,  S_NEXTB};
         S_COUNT:  word = '{OP_COUNT,  ADDR_CNEXT, C_C_LAST,   S_UPDATE, S_COUNT};
         S_UPDATE: word = '{OP_UPDATE, ADDR_A,     C_ALWAYS,   S_NEXTB,  S_NEXTB};
         S_NEXTB:  word = '{OP_STEP_B, ADDR_BNEXT, C_B_LAST,   S_NEXTA,  S_CHKB};
         S_NEXTA:  word = '{OP_STEP_A, ADDR_ANEXT, C_A_LAST,   S_DONE,   S_LDX};
         S_DONE:   word = '{OP_EMIT,   ADDR_A,     C_OUT_FREE, S_IDLE,   S_DONE};
         default:  word = '{OP_NONE,   ADDR_A,     C_ALWAYS,   S_IDLE,   S_IDLE};
      endcase
      return word;
   endfunction

endpackage

>>> rtl/core/max_rectangle_overlap_point_unit.sv
// Maximum rectangle overlap point.
// The req channel carries one rectangle per item; tlast marks the final
// rectangle of a set. Rectangles load at one item per cycle while idle.
// Malformed rectangles (start above end) and rectangles beyond the store
// depth are dropped and reported in the status field of the result.
// After the last item the sequencer searches the stored set. Every step of
// the search reads one stored rectangle through a single read port. For
// each candidate x it visits every y endpoint, and for each covering y
// endpoint it counts the hits over all stored rectangles. Each candidate x
// is covered at least by its own rectangle.
// An empty set goes from the check step straight to the emit step.
// The rsp channel carries one item per set. It sits in an output register,
// so the next set loads while a result waits; a stalled receiver only holds
// the sequencer in its final step until the register frees.
// Reset clears the rectangle count, the error flags and any pending result;
// the rectangle stores are not cleared, since only written entries are read.
module max_rectangle_overlap_point_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // x_start, x_end, y_start, y_end
   input  logic [mrop_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // best_x, best_y, max_count, status, zero padding
   output logic [mrop_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import mrop_pkg::*;

   ctrl_type  ctrl;
   flags_type flags;

   mrop_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   mrop_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .flags      (flags),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> rtl/core/mrop_ram.sv
module mrop_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> rtl/core/mrop_seq.sv
module mrop_seq (
   input  logic                clock,
   input  logic                reset,
   input  mrop_pkg::flags_type flags,
   output mrop_pkg::ctrl_type  ctrl
);

   import mrop_pkg::*;

   step_type  step_ff;
   step_type  step_in;
   uword_type word;
   logic      taken;

   assign word = ucode_rom(step_ff);

   always_comb begin
      unique case (word.cond)
         C_ALWAYS:   taken = 1'b1;
         C_START:    taken = flags.start;
         C_EMPTY:    taken = flags.empty;
         C_COVER:    taken = flags.covered;
         C_C_LAST:   taken = flags.c_last;
         C_B_LAST:   taken = flags.b_last;
         C_A_LAST:   taken = flags.a_last;
         C_OUT_FREE: taken = flags.out_free;
         default:    taken = 1'b1;
      endcase
      step_in = taken ? word.jump : word.next;
   end

   always_comb begin
      ctrl.op       = word.op;
      ctrl.addr_sel = word.addr_sel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

>>> rtl/core/mrop_datapath.sv
module mrop_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  mrop_pkg::ctrl_type                  ctrl,
   output mrop_pkg::flags_type                 flags,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mrop_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mrop_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   import mrop_pkg::*;

   coord_type in_xs, in_xe, in_ys, in_ye;
   coord_type rd_left, rd_right, rd_bottom, rd_top;
   logic      fire, malformed, full, wr_en;
   logic      covered, hit, better;
   logic [ADDR_W-1:0] rd_addr;

   logic [CNT_W-1:0]    rect_count_ff, rect_count_in;
   logic [STATUS_W-1:0] err_ff, err_in;
   logic [CAND_W-1:0]   a_ff, a_in, b_ff, b_in, last_cand;
   logic [ADDR_W-1:0]   c_ff, c_in;
   coord_type           x_ff, x_in, y_ff, y_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   coord_type           best_x_ff, best_x_in, best_y_ff, best_y_in;
   logic [CNT_W-1:0]    best_n_ff, best_n_in;
   logic                have_ff, have_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   assign in_xs = COORD_BITS'(req_tdata[FIELD_W-1:0]);
   assign in_xe = COORD_BITS'(req_tdata[2*FIELD_W-1:FIELD_W]);
   assign in_ys = COORD_BITS'(req_tdata[3*FIELD_W-1:2*FIELD_W]);
   assign in_ye = COORD_BITS'(req_tdata[4*FIELD_W-1:3*FIELD_W]);

   assign req_tready = (ctrl.op == OP_ACCEPT);
   assign fire       = req_tvalid && req_tready;
   assign malformed  = (in_xs > in_xe) || (in_ys > in_ye);
   assign full       = (rect_count_ff == CNT_W'(MAX_RECTS));
   assign wr_en      = fire && !malformed && !full;

   always_comb begin
      case (ctrl.addr_sel)
         ADDR_A:     rd_addr = ADDR_W'(a_ff >> 1);
         ADDR_B:     rd_addr = ADDR_W'(b_ff >> 1);
         ADDR_C0:    rd_addr = '0;
         ADDR_CNEXT: rd_addr = ADDR_W'(c_ff + 1'b1);
         ADDR_BNEXT: rd_addr = ADDR_W'((b_ff + 1'b1) >> 1);
         ADDR_ANEXT: rd_addr = ADDR_W'((a_ff + 1'b1) >> 1);
         default:    rd_addr = '0;
      endcase
   end

   mrop_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_RECTS)) u_left (
      .clock(clock), .wr_en(wr_en), .wr_addr(ADDR_W'(rect_count_ff)),
      .wr_data(in_xs), .rd_addr(rd_addr), .rd_data(rd_left)
   );
   mrop_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_RECTS)) u_right (
      .clock(clock), .wr_en(wr_en), .wr_addr(ADDR_W'(rect_count_ff)),
      .wr_data(in_xe), .rd_addr(rd_addr), .rd_data(rd_right)
   );
   mrop_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_RECTS)) u_bottom (
      .clock(clock), .wr_en(wr_en), .wr_addr(ADDR_W'(rect_count_ff)),
      .wr_data(in_ys), .rd_addr(rd_addr), .rd_data(rd_bottom)
   );
   mrop_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_RECTS)) u_top (
      .clock(clock), .wr_en(wr_en), .wr_addr(ADDR_W'(rect_count_ff)),
      .wr_data(in_ye), .rd_addr(rd_addr), .rd_data(rd_top)
   );

   // The rectangle on the read port is the one addressed in the previous step.
   assign covered = (rd_left <= x_ff) && (x_ff <= rd_right);
   assign hit     = covered && (rd_bottom <= y_ff) && (y_ff < rd_top);

   assign better = !have_ff || (cnt_ff > best_n_ff) ||
                   ((cnt_ff == best_n_ff) &&
                    ((x_ff < best_x_ff) || ((x_ff == best_x_ff) && (y_ff < best_y_ff))));

   assign last_cand = CAND_W'({rect_count_ff, 1'b0} - 1'b1);

   always_comb begin
      flags.start    = fire && req_tlast;
      flags.empty    = (rect_count_ff == '0);
      flags.covered  = covered;
      flags.c_last   = (c_ff == ADDR_W'(rect_count_ff - 1'b1));
      flags.b_last   = (b_ff == last_cand);
      flags.a_last   = (a_ff == last_cand);
      flags.out_free = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      rect_count_in = rect_count_ff;
      err_in        = err_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      c_in          = c_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      cnt_in        = cnt_ff;
      best_x_in     = best_x_ff;
      best_y_in     = best_y_ff;
      best_n_in     = best_n_ff;
      have_in       = have_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;

      unique case (ctrl.op)
         OP_ACCEPT: begin
            if (fire) begin
               if (malformed) begin
                  err_in[ERR_MALFORMED_BIT] = 1'b1;
               end else if (full) begin
                  err_in[ERR_OVERFLOW_BIT] = 1'b1;
               end else begin
                  rect_count_in = rect_count_ff + 1'b1;
               end
            end
         end
         OP_NONE: begin
         end
         OP_LOAD_X: begin
            x_in = a_ff[0] ? rd_right : rd_left;
         end
         OP_LOAD_Y: begin
            if (covered) begin
               y_in   = b_ff[0] ? rd_top : rd_bottom;
               c_in   = '0;
               cnt_in = '0;
            end
         end
         OP_COUNT: begin
            cnt_in = cnt_ff + CNT_W'(hit);
            c_in   = c_ff + 1'b1;
         end
         OP_UPDATE: begin
            if (better) begin
               have_in   = 1'b1;
               best_n_in = cnt_ff;
               best_x_in = x_ff;
               best_y_in = y_ff;
            end
         end
         OP_STEP_B: begin
            if (!flags.b_last) begin
               b_in = b_ff + 1'b1;
            end
         end
         OP_STEP_A: begin
            b_in = '0;
            if (!flags.a_last) begin
               a_in = a_ff + 1'b1;
            end
         end
         OP_EMIT: begin
            if (flags.out_free) begin
               rsp_valid_in = 1'b1;
               if (have_ff) begin
                  rsp_data_in = {{(RSP_DATA_W - RSP_USED_W){1'b0}}, err_ff,
                                 COUNT_W'(best_n_ff), FIELD_W'(best_y_ff),
                                 FIELD_W'(best_x_ff)};
               end else begin
                  rsp_data_in = {{(RSP_DATA_W - RSP_USED_W){1'b0}}, err_ff,
                                 {(RSP_USED_W - STATUS_W){1'b0}}};
               end
               rect_count_in = '0;
               err_in        = '0;
               a_in          = '0;
               b_in          = '0;
               have_in       = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_count_ff <= '0;
         err_ff        <= '0;
         a_ff          <= '0;
         b_ff          <= '0;
         have_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rect_count_ff <= rect_count_in;
         err_ff        <= err_in;
         a_ff          <= a_in;
         b_ff          <= b_in;
         have_ff       <= have_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      c_ff        <= c_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      cnt_ff      <= cnt_in;
      best_x_ff   <= best_x_in;
      best_y_ff   <= best_y_in;
      best_n_ff   <= best_n_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> rtl/core/mrop_checker.sv
module mrop_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            req_tlast,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [mrop_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import mrop_pkg::*;

   localparam int CNT_LO = 2 * FIELD_W;

   // A stalled result item holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   // The last rectangle of a set starts the search, which takes no items.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("item taken while the search runs");

   // Loading continues until the last rectangle arrives.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tlast |=> req_tready)
      else $error("loading stopped before the last item");

   // No count can exceed the store depth.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[CNT_LO +: COUNT_W] <= COUNT_W'(MAX_RECTS))
      else $error("overlap count beyond store depth");

endmodule

bind max_rectangle_overlap_point_unit mrop_checker u_checker (.*);
